// ===== hw/rtl/tlgt_pkg.sv =====
// Shared constants, types and tables for the two-link gravity torque block.
package tlgt_pkg;

    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int TABLE_LEN = 24;
    localparam int ANG_W = 32;
    localparam int XY_W = 33;
    localparam int COEF_W = 24;
    localparam int ANG_IN_W = 16;
    localparam int PAY_W = 16;
    localparam int NUM_REGS = 8;
    localparam int IDX_W = 3;

    localparam logic signed [ANG_W-1:0] ANG_PI = 32'sd843314857;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 32'sd421657428;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 32'sd1686629713;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = 33'sd652032874;
    localparam logic signed [ANG_IN_W+1:0] ELBOW_OFFSET = 18'sd1816;

    localparam logic signed [COEF_W-1:0] T_MAX = 24'sh7FFFFF;
    localparam logic signed [COEF_W-1:0] T_MIN = 24'sh800000;

    typedef enum logic [IDX_W-1:0] {
        REG_M1G_LC1 = 3'd0,
        REG_M1G_DC1 = 3'd1,
        REG_M2G_LC2 = 3'd2,
        REG_M2G_DC2 = 3'd3,
        REG_M2G_L1  = 3'd4,
        REG_G_L1    = 3'd5,
        REG_G_L2    = 3'd6,
        REG_TOOL    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    neg;
    } t_rot;

    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        begin
            unique case (idx)
                5'd0: v = 32'sd210828714;
                5'd1: v = 32'sd124459457;
                5'd2: v = 32'sd65760959;
                5'd3: v = 32'sd33381290;
                5'd4: v = 32'sd16755422;
                5'd5: v = 32'sd8385879;
                5'd6: v = 32'sd4193963;
                5'd7: v = 32'sd2097109;
                5'd8: v = 32'sd1048571;
                5'd9: v = 32'sd524287;
                default: v = 32'sd262144 >>> (idx - 5'd10);
            endcase
            atan_entry = v;
        end
    endfunction

endpackage

// ===== hw/rtl/tlgt_cordic_cell.sv =====
// One CORDIC rotation cell: a fixed-shift micro-rotation and its register.
module tlgt_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  tlgt_pkg::t_rot  i_rot,
    output tlgt_pkg::t_rot  o_rot
);
    import tlgt_pkg::*;

    t_rot r_rot;
    t_rot n_rot;

    always_comb begin
        n_rot = i_rot;
        if (!i_rot.z[ANG_W-1]) begin
            n_rot.x = i_rot.x - (i_rot.y >>> STEP);
            n_rot.y = i_rot.y + (i_rot.x >>> STEP);
            n_rot.z = i_rot.z - atan_entry(5'(STEP));
        end else begin
            n_rot.x = i_rot.x + (i_rot.y >>> STEP);
            n_rot.y = i_rot.y - (i_rot.x >>> STEP);
            n_rot.z = i_rot.z + atan_entry(5'(STEP));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
    end

    assign o_rot = r_rot;
endmodule

// ===== hw/rtl/tlgt_trig.sv =====
// Sine and cosine unit: range fold stage followed by a chain of CORDIC cells.
module tlgt_trig #(
    parameter int ITER = tlgt_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                                  i_clk,
    input  logic signed [tlgt_pkg::ANG_IN_W+1:0]  i_angle,
    output logic signed [tlgt_pkg::XY_W-1:0]      o_cos,
    output logic signed [tlgt_pkg::XY_W-1:0]      o_sin
);
    import tlgt_pkg::*;

    t_rot r_fold;
    t_rot n_fold;
    t_rot chain [0:ITER];
    logic signed [ANG_W+1:0] z_w;
    logic signed [ANG_W-1:0] z0;

    always_comb begin
        z_w = (ANG_W+2)'(i_angle) <<< 15;
        if (z_w > (ANG_W+2)'(ANG_PI)) begin
            z_w = z_w - (ANG_W+2)'(ANG_TWO_PI);
        end else if (z_w < -(ANG_W+2)'(ANG_PI)) begin
            z_w = z_w + (ANG_W+2)'(ANG_TWO_PI);
        end
        z0 = ANG_W'(z_w);
        n_fold.x = CORDIC_X0;
        n_fold.y = '0;
        n_fold.neg = 1'b0;
        n_fold.z = z0;
        if (z0 > ANG_HALF_PI) begin
            n_fold.z = z0 - ANG_PI;
            n_fold.neg = 1'b1;
        end else if (z0 < -ANG_HALF_PI) begin
            n_fold.z = z0 + ANG_PI;
            n_fold.neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fold <= n_fold;
    end

    assign chain[0] = r_fold;

    for (genvar g = 0; g < ITER; g++) begin : g_cell
        tlgt_cordic_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),
            .i_rot (chain[g]),
            .o_rot (chain[g+1])
        );
    end

    assign o_cos = chain[ITER].neg ? -chain[ITER].x : chain[ITER].x;
    assign o_sin = chain[ITER].neg ? -chain[ITER].y : chain[ITER].y;
endmodule

// ===== hw/rtl/two_link_gravity_torque.sv =====
// Two-link arm gravity torque: top level with config registers and torque pipeline.
// Throughput: one item per cycle; busy stays low, the CORDIC cell chain is fully pipelined.
// Reset: synchronous active-low; restores coefficient reset values and clears valid flags.
// Results appear for one cycle with o_valid; the receiver cannot stall.
module two_link_gravity_torque #(
    parameter int TRIG_ITERATIONS = tlgt_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [tlgt_pkg::ANG_IN_W-1:0]  i_shoulder_angle,
    input  logic signed [tlgt_pkg::ANG_IN_W-1:0]  i_elbow_angle,
    input  logic        [tlgt_pkg::PAY_W-1:0]     i_payload_mass,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [tlgt_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic signed [tlgt_pkg::COEF_W-1:0]    i_cfg_data,
    output logic                                  o_valid,
    output logic signed [tlgt_pkg::COEF_W-1:0]    o_shoulder_torque,
    output logic signed [tlgt_pkg::COEF_W-1:0]    o_elbow_torque,
    output logic signed [tlgt_pkg::COEF_W-1:0]    o_wrist_torque
);
    import tlgt_pkg::*;

    localparam int ITER = (TRIG_ITERATIONS > TABLE_LEN) ? TABLE_LEN : TRIG_ITERATIONS;
    localparam int LAT = ITER + 6;
    localparam int PL = ITER + 1;

    logic signed [COEF_W-1:0] r_coef [NUM_REGS];
    logic [LAT-1:0] r_vld;
    logic [PAY_W-1:0] r_pay [PL];

    logic signed [ANG_IN_W+1:0] ang_a;
    logic signed [ANG_IN_W+1:0] ang_b;
    logic signed [XY_W-1:0] c1, s1, c2, s2;

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[REG_M1G_LC1] <= 24'sd91089;
            r_coef[REG_M1G_DC1] <= 24'sd397;
            r_coef[REG_M2G_LC2] <= 24'sd104438;
            r_coef[REG_M2G_DC2] <= '0;
            r_coef[REG_M2G_L1]  <= 24'sd117787;
            r_coef[REG_G_L1]    <= 24'sd192873;
            r_coef[REG_G_L2]    <= 24'sd205730;
            r_coef[REG_TOOL]    <= '0;
            r_vld <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_coef[i_cfg_index] <= i_cfg_data;
            end
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    assign ang_a = (ANG_IN_W+2)'(i_shoulder_angle);
    assign ang_b = (ANG_IN_W+2)'(i_elbow_angle) - (ANG_IN_W+2)'(i_shoulder_angle)
                   + ELBOW_OFFSET;

    tlgt_trig #(.ITER(ITER)) u_trig_a (
        .i_clk(i_clk), .i_angle(ang_a), .o_cos(c1), .o_sin(s1));
    tlgt_trig #(.ITER(ITER)) u_trig_b (
        .i_clk(i_clk), .i_angle(ang_b), .o_cos(c2), .o_sin(s2));

    // payload delay line matching the trig latency
    always_ff @(posedge i_clk) begin
        r_pay[0] <= i_payload_mass;
        for (int k = 1; k < PL; k++) begin
            r_pay[k] <= r_pay[k-1];
        end
    end

    // stage 1: payload products, trig registered
    logic signed [41:0] pg1_raw, pg2_raw;
    logic signed [29:0] r_pg1, r_pg2;
    logic signed [XY_W-1:0] r1_c1, r1_s1, r1_c2, r1_s2;
    assign pg1_raw = $signed({1'b0, r_pay[PL-1]}) * r_coef[REG_G_L1] + 42'sd2048;
    assign pg2_raw = $signed({1'b0, r_pay[PL-1]}) * r_coef[REG_G_L2] + 42'sd2048;
    always_ff @(posedge i_clk) begin
        r_pg1 <= 30'(pg1_raw >>> 12);
        r_pg2 <= 30'(pg2_raw >>> 12);
        r1_c1 <= c1; r1_s1 <= s1; r1_c2 <= c2; r1_s2 <= s2;
    end

    // stage 2: coefficient sums
    logic signed [30:0] r_k1, r_k2;
    logic signed [XY_W-1:0] r2_c1, r2_s1, r2_c2, r2_s2;
    always_ff @(posedge i_clk) begin
        r_k1 <= 31'(r_coef[REG_M1G_LC1]) + 31'(r_coef[REG_M2G_L1]) + 31'(r_pg1);
        r_k2 <= 31'(r_coef[REG_M2G_LC2]) + 31'(r_pg2);
        r2_c1 <= r1_c1; r2_s1 <= r1_s1; r2_c2 <= r1_c2; r2_s2 <= r1_s2;
    end

    // stage 3: products
    logic signed [63:0] r_pc1, r_ps1, r_pc2, r_ps2;
    always_ff @(posedge i_clk) begin
        r_pc1 <= 64'(r_k1) * 64'(r2_c1);
        r_ps1 <= 64'(r_coef[REG_M1G_DC1]) * 64'(r2_s1);
        r_pc2 <= 64'(r_k2) * 64'(r2_c2);
        r_ps2 <= 64'(r_coef[REG_M2G_DC2]) * 64'(r2_s2);
    end

    // stage 4: sums
    logic signed [63:0] r_e, r_s;
    always_ff @(posedge i_clk) begin
        r_e <= r_pc2 - r_ps2;
        r_s <= r_pc1 - r_ps1 - (r_pc2 - r_ps2);
    end

    // stage 5: round and saturate
    function automatic logic signed [COEF_W-1:0] rsat(input logic signed [63:0] a);
        logic signed [63:0] v;
        begin
            v = (a + 64'sd536870912) >>> 30;
            if (v > 64'(T_MAX)) begin
                rsat = T_MAX;
            end else if (v < 64'(T_MIN)) begin
                rsat = T_MIN;
            end else begin
                rsat = v[COEF_W-1:0];
            end
        end
    endfunction

    logic signed [COEF_W-1:0] r_sh, r_el;
    always_ff @(posedge i_clk) begin
        r_sh <= rsat(r_s);
        r_el <= rsat(r_e);
    end

    assign o_valid = r_vld[LAT-1];
    assign o_shoulder_torque = r_sh;
    assign o_elbow_torque = r_el;
    assign o_wrist_torque = r_coef[REG_TOOL];
endmodule

// ===== hw/rtl/tlgt_checker.sv =====
// Port-level checker for the two-link gravity torque block, with its bind.
module tlgt_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_cfg_ready,
    input logic                                o_valid,
    input logic signed [tlgt_pkg::COEF_W-1:0]  o_wrist_torque
);
    import tlgt_pkg::*;

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("cfg not ready");
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_tool_reset: assert property (@(posedge i_clk) !i_rst_n |=> o_wrist_torque == '0)
        else $error("wrist reset");
endmodule

bind two_link_gravity_torque tlgt_checker u_tlgt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_cfg_ready(o_cfg_ready), .o_valid(o_valid), .o_wrist_torque(o_wrist_torque));
